>>> sv/gmt_pkg.sv
// ----------------------------------------------------------------------------
// gmt_pkg
// shared constants for the grid mesh triangulator: register indexes,
// reset values, field widths and edge numbering
// ----------------------------------------------------------------------------
package gmt_pkg;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_WIDTH     = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_EDGE_THRESHOLD = 1'b1;

  // register widths and reset values
  localparam int GW_BITS  = 11;
  localparam int THR_BITS = 16;

  localparam logic [GW_BITS-1:0]  GRID_WIDTH_RESET = 11'd640;
  localparam logic [THR_BITS-1:0] THRESHOLD_RESET  = 16'd100;

  // squared distance arithmetic
  localparam int SQ_BITS  = 2 * THR_BITS;
  localparam int SUM_BITS = SQ_BITS + 2;

  // edges of one grid cell, each tested once
  localparam int AXES       = 3;
  localparam int EDGE_COUNT = 5;
  localparam int E_UL_L     = 0;  // upper-left to left
  localparam int E_UL_UR    = 1;  // upper-left to upper-right
  localparam int E_L_UR     = 2;  // left to upper-right (shared diagonal)
  localparam int E_UR_CUR   = 3;  // upper-right to current
  localparam int E_L_CUR    = 4;  // left to current

  typedef logic [THR_BITS-1:0] thr_t;
  typedef logic [SQ_BITS-1:0]  sq_t;
  typedef logic [SUM_BITS-1:0] sum_t;

endpackage

>>> sv/grid_mesh_triangulator_core.sv
// ----------------------------------------------------------------------------
// grid_mesh_triangulator_core
// organized point-cloud grid triangulation: raster vertices in, triangle
// corner indices out
// ----------------------------------------------------------------------------
// Vertices arrive in raster order, one per request, and every vertex past the
// first row and first column closes a grid cell. Two triangles are tested per
// cell, (upper-left, lower-left, upper-right) and (upper-right, lower-left,
// current); a triangle passes when its three corners are valid and each edge
// is shorter than edge_threshold (squared compare, strict). Each passing
// triangle leaves as one output request, first triangle first, with run_last
// set on the last one caused by the vertex. Rate: one vertex per cycle while
// the output is not stalled; the result register holds a vertex with two
// passing triangles until both have left by the single output port, and the
// stages behind it can stall meanwhile. Each vertex moves through the stage
// registers and then the result register. The previous row lives in one
// single-port read-first memory, read and written at the vertex's column in
// the cycle of acceptance, so no forwarding is needed and no clearing pass
// runs after reset. The user must write configuration only while the block is
// idle; the block does not enforce this. A write takes effect on the next vertex.
// ----------------------------------------------------------------------------
module grid_mesh_triangulator_core #(
  parameter int MAX_ROW_LENGTH = 1024,
  parameter int INDEX_BITS     = 20,
  parameter int COORD_BITS     = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [gmt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [gmt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // vertex requests
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                frame_start,
  input  logic                                vertex_valid,
  input  logic signed [COORD_BITS-1:0]        pos_x,
  input  logic signed [COORD_BITS-1:0]        pos_y,
  input  logic signed [COORD_BITS-1:0]        pos_z,
  // triangle requests
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [INDEX_BITS-1:0]               corner_first,
  output logic [INDEX_BITS-1:0]               corner_second,
  output logic [INDEX_BITS-1:0]               corner_third,
  output logic                                run_last
);
  import gmt_pkg::*;

  // column address, width compare and index arithmetic widths
  localparam int CB   = $clog2(MAX_ROW_LENGTH);
  localparam int WB   = $clog2(MAX_ROW_LENGTH + 1);
  localparam int CMPW = (WB > GW_BITS) ? WB : GW_BITS;
  localparam int SW   = (INDEX_BITS > WB) ? INDEX_BITS : WB;
  // vertex word: {valid, x, y, z}
  localparam int MW   = 3 * COORD_BITS + 1;
  localparam int DW   = COORD_BITS + 1;
  localparam int AW   = (COORD_BITS > THR_BITS) ? COORD_BITS : THR_BITS;

  localparam logic [CMPW-1:0] MAX_W = CMPW'(MAX_ROW_LENGTH);
  localparam logic [CMPW-1:0] MIN_W = CMPW'(2);

  // configuration registers
  logic [GW_BITS-1:0] grid_width;
  thr_t               edge_threshold;
  sq_t                thr_sq;

  // raster position
  logic [CB-1:0]         column_count;
  logic                  row_nonzero;
  logic [INDEX_BITS-1:0] vertex_index;

  // row store
  logic [MW-1:0] row_mem [MAX_ROW_LENGTH];
  logic [MW-1:0] ur_q;

  // neighbours of the vertex in stage one
  logic [MW-1:0] left_q;
  logic [MW-1:0] ul_q;

  // pipeline control: stages 1..4 then the result register
  logic       stage_v   [1:4];
  logic       stage_ld  [1:4];
  logic       cell_pipe [1:4];
  logic [INDEX_BITS-1:0] i3_pipe [1:4];
  logic [INDEX_BITS-1:0] i1_pipe [1:4];
  logic       tva_pipe  [2:4];
  logic       tvb_pipe  [2:4];
  logic       res_ld;
  logic       accept;

  // stage payloads
  logic [MW-1:0]                cur1;
  logic signed [DW-1:0]         diff_d [EDGE_COUNT][AXES];
  logic signed [DW-1:0]         diff_q [EDGE_COUNT][AXES];
  thr_t                         mag_d  [EDGE_COUNT][AXES];
  logic                         far_d  [EDGE_COUNT][AXES];
  thr_t                         mag_q  [EDGE_COUNT][AXES];
  logic                         far_q  [EDGE_COUNT][AXES];
  sq_t                          sq_q   [EDGE_COUNT][AXES];
  logic                         far4_q [EDGE_COUNT];
  logic                         edge_ok [EDGE_COUNT];
  logic [MW-1:0]                end_a [EDGE_COUNT];
  logic [MW-1:0]                end_b [EDGE_COUNT];

  // result register
  logic                  tri_a_pend;
  logic                  tri_b_pend;
  logic [INDEX_BITS-1:0] r_i0, r_i1, r_i2, r_i3;
  logic                  out_take;

  // front end signals
  logic [CMPW-1:0]       gw_ext;
  logic [WB-1:0]         w_eff;
  logic [CB-1:0]         base_col;
  logic [CB-1:0]         col;
  logic [WB-1:0]         col_inc;
  logic [INDEX_BITS-1:0] idx_cur;
  logic                  row_cur;
  logic [SW-1:0]         i1_wide;
  logic [INDEX_BITS-1:0] i1_cur;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= GRID_WIDTH_RESET;
      edge_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:     grid_width     <= cfg_data[GW_BITS-1:0];
        CFG_EDGE_THRESHOLD: edge_threshold <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // squared threshold, ready long before the first vertex reaches the compare
  always_ff @(posedge clk) begin
    thr_sq <= SQ_BITS'(edge_threshold) * SQ_BITS'(edge_threshold);
  end

  // --------------------------------------------------------------------------
  // handshake chain: a stage loads when empty or when it drains this cycle
  // --------------------------------------------------------------------------
  assign out_take = out_valid && out_ready;
  // result register frees when nothing is pending or its last triangle leaves
  assign res_ld   = !(tri_a_pend || tri_b_pend) ||
                    (out_ready && !(tri_a_pend && tri_b_pend));

  always_comb begin
    stage_ld[4] = !stage_v[4] || res_ld;
    stage_ld[3] = !stage_v[3] || stage_ld[4];
    stage_ld[2] = !stage_v[2] || stage_ld[3];
    stage_ld[1] = !stage_v[1] || stage_ld[2];
  end

  assign in_ready = stage_ld[1];
  assign accept   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // front end: column, row and index of the incoming vertex
  // --------------------------------------------------------------------------
  always_comb begin
    // clamp the programmed width to the row store
    gw_ext = CMPW'(grid_width);
    if (gw_ext < MIN_W) begin
      w_eff = WB'(MIN_W);
    end else if (gw_ext > MAX_W) begin
      w_eff = WB'(MAX_W);
    end else begin
      w_eff = WB'(gw_ext);
    end

    // frame start restarts the raster before this vertex is used
    base_col = frame_start ? '0 : column_count;
    row_cur  = frame_start ? 1'b0 : row_nonzero;
    idx_cur  = frame_start ? '0 : vertex_index;

    // a column at or past the row end wraps to zero
    col     = (WB'(base_col) >= w_eff) ? '0 : base_col;
    col_inc = WB'(col) + WB'(1);

    // index of the upper-right corner
    i1_wide = SW'(idx_cur) - SW'(w_eff);
    i1_cur  = i1_wide[INDEX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_nonzero  <= 1'b0;
      vertex_index <= '0;
    end else if (accept) begin
      vertex_index <= idx_cur + INDEX_BITS'(1);
      if (col_inc >= w_eff) begin
        column_count <= '0;
        row_nonzero  <= 1'b1;
      end else begin
        column_count <= col_inc[CB-1:0];
        row_nonzero  <= row_cur;
      end
    end
  end

  // row store: read-first, the old entry comes out as the upper-right corner
  always_ff @(posedge clk) begin
    if (accept) begin
      ur_q         <= row_mem[col];
      row_mem[col] <= {vertex_valid, pos_x, pos_y, pos_z};
    end
  end

  // --------------------------------------------------------------------------
  // stage valids
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= 4; s++) begin
        stage_v[s] <= 1'b0;
      end
    end else begin
      if (stage_ld[1]) begin
        stage_v[1] <= accept;
      end
      for (int s = 2; s <= 4; s++) begin
        if (stage_ld[s]) begin
          stage_v[s] <= stage_v[s-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: current vertex next to its neighbours
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      cur1         <= {vertex_valid, pos_x, pos_y, pos_z};
      cell_pipe[1] <= row_cur && (col != '0);
      i3_pipe[1]   <= idx_cur;
      i1_pipe[1]   <= i1_cur;
    end
  end

  // neighbours advance as the vertex leaves stage 1
  always_ff @(posedge clk) begin
    if (stage_v[1] && stage_ld[2]) begin
      left_q <= cur1;
      ul_q   <= ur_q;
    end
  end

  always_comb begin
    end_a[E_UL_L]   = ul_q;  end_b[E_UL_L]   = left_q;
    end_a[E_UL_UR]  = ul_q;  end_b[E_UL_UR]  = ur_q;
    end_a[E_L_UR]   = left_q; end_b[E_L_UR]  = ur_q;
    end_a[E_UR_CUR] = ur_q;  end_b[E_UR_CUR] = cur1;
    end_a[E_L_CUR]  = left_q; end_b[E_L_CUR] = cur1;
  end

  // signed component differences, one lane per edge and axis
  always_comb begin
    for (int e = 0; e < EDGE_COUNT; e++) begin
      for (int k = 0; k < AXES; k++) begin
        diff_d[e][k] =
          $signed({end_a[e][k*COORD_BITS + COORD_BITS - 1],
                   end_a[e][k*COORD_BITS +: COORD_BITS]}) -
          $signed({end_b[e][k*COORD_BITS + COORD_BITS - 1],
                   end_b[e][k*COORD_BITS +: COORD_BITS]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ld[2]) begin
      diff_q       <= diff_d;
      cell_pipe[2] <= cell_pipe[1];
      i3_pipe[2]   <= i3_pipe[1];
      i1_pipe[2]   <= i1_pipe[1];
      tva_pipe[2]  <= ul_q[MW-1] && left_q[MW-1] && ur_q[MW-1];
      tvb_pipe[2]  <= ur_q[MW-1] && left_q[MW-1] && cur1[MW-1];
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: magnitudes and the coarse per-axis reject
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [DW-1:0] mag_full;
    logic [AW-1:0]        mag_ext;
    for (int e = 0; e < EDGE_COUNT; e++) begin
      for (int k = 0; k < AXES; k++) begin
        mag_full     = diff_q[e][k][DW-1] ? -diff_q[e][k] : diff_q[e][k];
        mag_ext      = AW'(mag_full[COORD_BITS-1:0]);
        far_d[e][k]  = mag_ext >= AW'(edge_threshold);
        mag_d[e][k]  = mag_ext[THR_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ld[3]) begin
      mag_q        <= mag_d;
      far_q        <= far_d;
      cell_pipe[3] <= cell_pipe[2];
      i3_pipe[3]   <= i3_pipe[2];
      i1_pipe[3]   <= i1_pipe[2];
      tva_pipe[3]  <= tva_pipe[2];
      tvb_pipe[3]  <= tvb_pipe[2];
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: squares, 16 by 16 per lane
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (stage_ld[4]) begin
      for (int e = 0; e < EDGE_COUNT; e++) begin
        for (int k = 0; k < AXES; k++) begin
          sq_q[e][k] <= SQ_BITS'(mag_q[e][k]) * SQ_BITS'(mag_q[e][k]);
        end
        far4_q[e] <= far_q[e][0] || far_q[e][1] || far_q[e][2];
      end
      cell_pipe[4] <= cell_pipe[3];
      i3_pipe[4]   <= i3_pipe[3];
      i1_pipe[4]   <= i1_pipe[3];
      tva_pipe[4]  <= tva_pipe[3];
      tvb_pipe[4]  <= tvb_pipe[3];
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: squared length against the squared threshold
  // --------------------------------------------------------------------------
  always_comb begin
    for (int e = 0; e < EDGE_COUNT; e++) begin
      edge_ok[e] = !far4_q[e] &&
                   ((SUM_BITS'(sq_q[e][0]) + SUM_BITS'(sq_q[e][1]) +
                     SUM_BITS'(sq_q[e][2])) < SUM_BITS'(thr_sq));
    end
  end

  // --------------------------------------------------------------------------
  // result register: up to two triangles, sent one per output request
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      tri_a_pend <= 1'b0;
      tri_b_pend <= 1'b0;
    end else if (res_ld) begin
      tri_a_pend <= stage_v[4] && cell_pipe[4] && tva_pipe[4] &&
                    edge_ok[E_UL_L] && edge_ok[E_UL_UR] && edge_ok[E_L_UR];
      tri_b_pend <= stage_v[4] && cell_pipe[4] && tvb_pipe[4] &&
                    edge_ok[E_L_UR] && edge_ok[E_UR_CUR] && edge_ok[E_L_CUR];
    end else if (out_take) begin
      // both pending and the first one leaves
      tri_a_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ld) begin
      r_i3 <= i3_pipe[4];
      r_i2 <= i3_pipe[4] - INDEX_BITS'(1);
      r_i1 <= i1_pipe[4];
      r_i0 <= i1_pipe[4] - INDEX_BITS'(1);
    end
  end

  assign out_valid     = tri_a_pend || tri_b_pend;
  assign corner_first  = tri_a_pend ? r_i0 : r_i1;
  assign corner_second = r_i2;
  assign corner_third  = tri_a_pend ? r_i1 : r_i3;
  assign run_last      = !(tri_a_pend && tri_b_pend);

`ifndef ASSERT_OFF
  // a lone pending triangle is always the last of its vertex
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !(tri_a_pend && tri_b_pend)) |-> run_last)
    else $error("lone triangle without run_last");

  // the first of two triangles leaves, the second stays
  assert property (@(posedge clk) disable iff (rst)
    (tri_a_pend && tri_b_pend && out_ready) |=> (!tri_a_pend && tri_b_pend))
    else $error("triangle pair not serialized");

  // an accepted vertex is in stage 1 on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    accept |=> stage_v[1])
    else $error("accepted vertex lost at stage 1");

  // input back-pressure only while the front stage holds a vertex
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> stage_v[1])
    else $error("input stalled with an empty front stage");
`endif

endmodule

>>> tb/grid_mesh_triangulator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_mesh_triangulator_core_tb
// self-checking bench for the grid mesh triangulator core
// ----------------------------------------------------------------------------
// Streams vertex requests in raster order and predicts every triangle
// request with an independent model of the line store, neighbor registers
// and edge tests. Covers coordinate extremes, invalid markers, the strict
// edge compare, zero and full-scale thresholds, clamped widths, widths
// lowered mid-grid, random surfaces under random back-pressure, and a short
// closing grid at the default threshold.
// ----------------------------------------------------------------------------
module grid_mesh_triangulator_core_tb;
  import gmt_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int INDEX_W       = 20;
  localparam int COORD_W       = 24;
  localparam int ROW_SAT       = 1023;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int TAIL_ITEMS    = 80;
  localparam int SETTLE_CYCLES = 12;     // margin for the pipeline to drain
  localparam int STALL_LIMIT   = 4000;   // cycles with no request moving

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct {
    logic                      ok;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic [INDEX_W-1:0] first;
    logic [INDEX_W-1:0] second;
    logic [INDEX_W-1:0] third;
    logic               last;
  } triangle_t;

  // --------------------------------------------------------------------------
  // triangle predictor and expected-triangle store
  // --------------------------------------------------------------------------
  class tri_scoreboard;
    vertex_t             row_mem [MAX_W];
    vertex_t             left_v;
    vertex_t             upper_left_v;
    int unsigned         col;
    int unsigned         row;
    logic [INDEX_W-1:0]  next_index;
    logic [GW_BITS-1:0]  width_reg;
    logic [THR_BITS-1:0] thr_reg;
    triangle_t           expected_q[$];
    int                  errors;

    function new();
      foreach (row_mem[i]) row_mem[i] = '{default: '0};
      left_v       = '{default: '0};
      upper_left_v = '{default: '0};
      col          = 0;
      row          = 0;
      next_index   = '0;
      width_reg    = GRID_WIDTH_RESET;
      thr_reg      = THRESHOLD_RESET;
      errors       = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < 2) return 2;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function void configure(input logic [CFG_INDEX_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_GRID_WIDTH:     width_reg = data[GW_BITS-1:0];
        CFG_EDGE_THRESHOLD: thr_reg = data[THR_BITS-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned span(input logic signed [COORD_W-1:0] a,
                                   input logic signed [COORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return (d < 0) ? -d : d;
    endfunction

    // strict squared compare, per-axis early out as in the block
    function bit edge_short(input vertex_t a, input vertex_t b);
      longint unsigned t, dx, dy, dz;
      t  = thr_reg;
      dx = span(a.x, b.x);
      dy = span(a.y, b.y);
      dz = span(a.z, b.z);
      if (dx >= t || dy >= t || dz >= t) return 1'b0;
      return (dx * dx + dy * dy + dz * dz) < (t * t);
    endfunction

    function bit tri_passes(input vertex_t a, input vertex_t b, input vertex_t c);
      return a.ok && b.ok && c.ok &&
             edge_short(a, b) && edge_short(a, c) && edge_short(b, c);
    endfunction

    function void note_vertex(input bit fs, input vertex_t cur);
      int unsigned        w, c;
      vertex_t            ur;
      logic [INDEX_W-1:0] i0, i1, i2, i3;
      bit                 first_ok, second_ok;
      w = eff_width();
      if (fs) begin
        col        = 0;
        row        = 0;
        next_index = '0;
      end
      if (col >= w) col = 0;
      c  = col;
      ur = row_mem[c];
      if (row > 0 && c > 0) begin
        i3 = next_index;
        i2 = i3 - INDEX_W'(1);
        i1 = i3 - INDEX_W'(w);
        i0 = i1 - INDEX_W'(1);
        first_ok  = tri_passes(upper_left_v, left_v, ur);
        second_ok = tri_passes(ur, left_v, cur);
        if (first_ok) expected_q.push_back(triangle_t'{i0, i2, i1, !second_ok});
        if (second_ok) expected_q.push_back(triangle_t'{i1, i2, i3, 1'b1});
      end
      upper_left_v = ur;
      left_v       = cur;
      row_mem[c]   = cur;
      next_index   = next_index + 1'b1;
      if (c + 1 >= w) begin
        col = 0;
        if (row < ROW_SAT) row++;
      end else begin
        col = c + 1;
      end
    endfunction

    function void check_triangle(input triangle_t got);
      triangle_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected triangle: expected none, actual %0d %0d %0d last %0b",
                   got.first, got.second, got.third, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"triangle mismatch: expected %0d %0d %0d last %0b, ",
                    "actual %0d %0d %0d last %0b"},
                   want.first, want.second, want.third, want.last,
                   got.first, got.second, got.third, got.last);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // dut and its signals
  // --------------------------------------------------------------------------
  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_INDEX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0]   cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic                       frame_start;
  logic                       vertex_valid;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic signed [COORD_W-1:0]  pos_z;
  logic                       out_valid;
  logic                       out_ready;
  logic [INDEX_W-1:0]         corner_first;
  logic [INDEX_W-1:0]         corner_second;
  logic [INDEX_W-1:0]         corner_third;
  logic                       run_last;

  grid_mesh_triangulator_core #(
    .MAX_ROW_LENGTH(MAX_W),
    .INDEX_BITS    (INDEX_W),
    .COORD_BITS    (COORD_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .frame_start  (frame_start),
    .vertex_valid (vertex_valid),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .corner_first (corner_first),
    .corner_second(corner_second),
    .corner_third (corner_third),
    .run_last     (run_last)
  );

  tri_scoreboard sb;
  vertex_t       accepted_vertex;

  // idle rates in percent, changed by the stimulus phases
  int send_idle;
  int recv_idle;

  // set when the width grows: the next vertex must open a new grid so the
  // line store is never read at a column that was never written
  bit need_frame;

  // shape of the current random surface
  int          surf_x, surf_y, surf_z;
  int unsigned surf_step;
  int unsigned surf_noise;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, decided once per cycle on the falling edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // accepted requests on both sides, sampled at the rising edge;
  // inputs go to the predictor first, though latency keeps them apart anyway
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        accepted_vertex.ok = vertex_valid;
        accepted_vertex.x  = pos_x;
        accepted_vertex.y  = pos_y;
        accepted_vertex.z  = pos_z;
        sb.note_vertex(frame_start, accepted_vertex);
      end
      if (out_valid === 1'b1 && out_ready)
        sb.check_triangle(triangle_t'{corner_first, corner_second, corner_third, run_last});
    end
  end

  // watchdog: ends the run when no request moves for too long
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // driving tasks, all entered and left on a falling edge
  // --------------------------------------------------------------------------

  // one vertex request; valid holds with a fixed payload until accepted
  task automatic send_vertex(input bit fs, input bit ok,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    if (fs) need_frame = 1'b0;
    in_valid     <= 1'b1;
    frame_start  <= fs;
    vertex_valid <= ok;
    pos_x        <= x;
    pos_y        <= y;
    pos_z        <= z;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  // stop sending, let every expected triangle out, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // enable is raised with the write, then lowered and held low before the task
  // returns, so back-to-back writes never pulse it within one step
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.configure(idx, data);
    @(negedge clk);
  endtask

  task automatic set_width(input int unsigned w);
    int unsigned old_w;
    old_w = sb.eff_width();
    write_reg(CFG_GRID_WIDTH, CFG_DATA_BITS'(w));
    if (sb.eff_width() > old_w) need_frame = 1'b1;
  endtask

  // spacing tracks the threshold so edges land on both sides of it
  task automatic new_surface(input bit with_base);
    if (with_base) begin
      surf_x = $urandom;
      surf_y = $urandom;
      surf_z = $urandom;
    end
    surf_step  = $urandom_range(int'(sb.thr_reg) * 3 / 4);
    surf_noise = $urandom_range(int'(sb.thr_reg) / 4 + 1);
  endtask

  function automatic int jitter();
    return int'($urandom_range(2 * surf_noise)) - int'(surf_noise);
  endfunction

  // mostly a noisy regular surface, some full-range noise, a few new grids
  task automatic send_random_item();
    bit          fs;
    int unsigned c, r;
    fs = need_frame || ($urandom_range(99) < 2);
    if (fs) new_surface(1'b1);
    c = fs ? 0 : ((sb.col >= sb.eff_width()) ? 0 : sb.col);
    r = fs ? 0 : sb.row;
    if ($urandom_range(99) < 10)
      send_vertex(fs, 1'($urandom_range(1)), COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom));
    else
      send_vertex(fs, $urandom_range(99) >= 8,
                  COORD_W'(surf_x + c * surf_step + jitter()),
                  COORD_W'(surf_y + r * surf_step + jitter()),
                  COORD_W'(surf_z + jitter()));
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int items_sent;
    int seg_len;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_GRID_WIDTH;
    cfg_data     = '0;
    in_valid     = 1'b0;
    frame_start  = 1'b0;
    vertex_valid = 1'b0;
    pos_x        = '0;
    pos_y        = '0;
    pos_z        = '0;
    send_idle    = 25;
    recv_idle    = 73;
    need_frame   = 1'b1;
    surf_x       = 0;
    surf_y       = 0;
    surf_z       = 0;
    surf_step    = 0;
    surf_noise   = 0;
    sb           = new();

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset settings: a few vertices of a wide first row, no cell closes
    send_vertex(1'b1, 1'b1, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    repeat (2)
      send_vertex(1'b0, 1'b1, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));

    // width zero clamps to two; full-scale threshold
    wait_idle();
    set_width(0);
    write_reg(CFG_EDGE_THRESHOLD, 16'hFFFF);
    // all corners at the positive corner: both triangles pass
    send_vertex(1'b1, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
    repeat (3) send_vertex(1'b0, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
    // jump to the negative corner: every axis distance exceeds the threshold
    repeat (2) send_vertex(1'b0, 1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
    // flat at the negative corner: both pass again
    repeat (2) send_vertex(1'b0, 1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
    // invalid left corner kills both triangles
    send_vertex(1'b0, 1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
    send_vertex(1'b0, 1'b1, COORD_MIN, COORD_MIN, COORD_MIN);

    // threshold 5: squared length exactly 25 fails, 12 passes, 48 fails
    wait_idle();
    write_reg(CFG_EDGE_THRESHOLD, 16'd5);
    set_width(2);
    send_vertex(1'b1, 1'b1, 0, 0, 0);
    send_vertex(1'b0, 1'b1, 3, 4, 0);
    send_vertex(1'b0, 1'b1, 0, 0, 0);
    send_vertex(1'b0, 1'b1, 2, 2, 2);
    send_vertex(1'b0, 1'b1, 1, 1, 1);
    send_vertex(1'b0, 1'b1, -2, -2, -2);

    // zero threshold: even coincident corners fail
    wait_idle();
    write_reg(CFG_EDGE_THRESHOLD, 16'd0);
    repeat (2) send_vertex(1'b0, 1'b1, 0, 0, 0);

    // random segments, each with any new settings written while idle;
    // idle mix: sender light / receiver heavy, then swapped, then none
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_idle();
      case (items_sent * 3 / RANDOM_ITEMS)
        0: begin
          send_idle = 25;
          recv_idle = 73;
        end
        1: begin
          send_idle = 73;
          recv_idle = 25;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      // unchanged or lowered width keeps the grid going mid-row
      if ($urandom_range(1)) begin
        case ($urandom_range(9))
          0: set_width(0);
          1: set_width(1);
          2: set_width(2);
          3: set_width($urandom_range(6, 3));
          4: set_width($urandom_range(40, 7));
          default: set_width($urandom_range(12, 2));
        endcase
      end
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0: write_reg(CFG_EDGE_THRESHOLD, 16'd1);
          1: write_reg(CFG_EDGE_THRESHOLD, 16'hFFFF);
          2: write_reg(CFG_EDGE_THRESHOLD, CFG_DATA_BITS'($urandom_range(65534, 2)));
          3: write_reg(CFG_EDGE_THRESHOLD, 16'd0);
          default: write_reg(CFG_EDGE_THRESHOLD, CFG_DATA_BITS'($urandom_range(400, 20)));
        endcase
      end
      new_surface(1'b0);
      seg_len = $urandom_range(160, 40);
      repeat (seg_len) send_random_item();
      items_sent += seg_len;
    end

    // small noisy grid at the default threshold, with stalls on both sides
    wait_idle();
    send_idle = 25;
    recv_idle = 73;
    set_width(7);
    write_reg(CFG_EDGE_THRESHOLD, 16'd100);
    for (int i = 0; i < TAIL_ITEMS; i++)
      send_vertex(i == 0, $urandom_range(99) >= 5,
                  COORD_W'(int'($urandom_range(40)) - 20),
                  COORD_W'(int'($urandom_range(40)) - 20),
                  COORD_W'(int'($urandom_range(40)) - 20));

    wait_idle();
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
